// ===== src/ptg_pkg.sv =====
// Package for the periodic tone generator: register map, reset values, states,
// square-wave levels and the CORDIC arctangent table.
// No dependencies.
package ptg_pkg;

    localparam int PHASE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int SR_W   = 18;
    localparam int TF_W   = 17;
    localparam int IDX_W  = 18;
    localparam int NUM_W  = 19;
    localparam int SMP_W  = 16;
    localparam int ADDR_W = 4;

    localparam logic [SR_W-1:0] SAMPLE_RATE_RST = 18'd44100;
    localparam logic [TF_W-1:0] TONE_FREQ_RST   = 17'd440;

    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_TONE_FREQ   = 2'd1;
    localparam logic [1:0] REG_WAVEFORM    = 2'd2;

    localparam logic signed [SMP_W-1:0] SQ_HIGH = 16'sd32767;
    localparam logic signed [SMP_W-1:0] SQ_LOW  = -16'sd32767;

    localparam logic signed [17:0] CORDIC_GAIN = 18'sd19898;
    localparam logic signed [17:0] Y_MAX       = 18'sd32767;
    localparam logic signed [17:0] Y_MIN       = -18'sd32767;
    localparam logic signed [32:0] QUARTER     = 33'sd1073741824;
    localparam logic signed [32:0] HALF        = 33'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVN,
        ST_PREP,
        ST_DIVP,
        ST_CINIT,
        ST_CORD,
        ST_FIN,
        ST_DONE
    } state_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] t;
        case (k)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2FA;
            5'd15:   t = 32'h0000517D;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A30;
            5'd19:   t = 32'h00000518;
            5'd20:   t = 32'h0000028C;
            5'd21:   t = 32'h00000146;
            5'd22:   t = 32'h000000A3;
            5'd23:   t = 32'h00000051;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// ===== src/periodic_tone_generator_top.sv =====
// Periodic tone generator: period by serial division, phase by serial division,
// sine by an iterative CORDIC, square by compare. Uses ptg_pkg.
//
//  channel   | ports                      | beat contents
//  ----------+----------------------------+----------------------------------------
//  input     | s_tvalid s_tready s_tdata  | tdata[0] restart
//  output    | m_tvalid m_tready m_tdata  | tdata[15:0] sample_value, tlast last_of_period
//            | m_tlast                    |
//  config    | psel penable pwrite paddr  | 0x0 sample_rate, 0x4 tone_freq, 0x8 waveform
//            | pwdata prdata pready       |
//
// The shared restoring subtractor runs 19 steps for the period, PHASE_BITS for the phase;
// the CORDIC add/shift unit runs CORDIC_STEPS steps. s_tready is high only when idle.
// A finished sample waits in DONE while the output register is held by m_tready low.
// aresetn is synchronous; it restores register defaults and index zero.
module periodic_tone_generator_top #(
    parameter int PHASE_BITS   = ptg_pkg::PHASE_BITS_DEF,
    parameter int CORDIC_STEPS = ptg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] restart
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,   // [15:0] sample_value
    output logic                      m_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ptg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import ptg_pkg::*;

    localparam int MAX_A    = (PHASE_BITS > NUM_W) ? PHASE_BITS : NUM_W;
    localparam int MAX_IT   = (MAX_A > CORDIC_STEPS) ? MAX_A : CORDIC_STEPS;
    localparam int CNT_W    = $clog2(MAX_IT + 1);
    localparam int QW       = MAX_A;

    state_t                   state_reg, state_next;
    logic [SR_W-1:0]          sr_reg, sr_next;
    logic [TF_W-1:0]          tf_reg, tf_next;
    logic                     wf_reg, wf_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     mv_reg, mv_next;
    logic [15:0]              md_reg, md_next;
    logic                     ml_reg, ml_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [IDX_W-1:0]         div_reg, div_next;
    logic [NUM_W-1:0]         rem_reg, rem_next;
    logic [QW-1:0]            q_reg, q_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         n_reg, n_next;
    logic [PHASE_BITS-1:0]    ph_reg, ph_next;
    logic signed [17:0]       x_reg, x_next;
    logic signed [17:0]       y_reg, y_next;
    logic signed [32:0]       z_reg, z_next;
    logic signed [SMP_W-1:0]  val_reg, val_next;
    logic                     last_reg, last_next;

    logic                     wr_en;
    logic [TF_W-1:0]          f_eff;
    logic                     bit_in;
    logic [NUM_W-1:0]         rem_sh;
    logic [NUM_W:0]           trial;
    logic                     ge;
    logic [QW-1:0]            q_sh;
    logic [IDX_W-1:0]         i_eff;
    logic                     is_last;
    logic [31:0]              a32;
    logic signed [32:0]       z_in;
    logic signed [17:0]       dx, dy;
    logic signed [32:0]       at;
    logic signed [SMP_W-1:0]  y_c;
    logic [16:0]              y_off;
    logic [31:0]              prod;

    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign f_eff  = (tf_reg == '0) ? TF_W'(1) : tf_reg;

    // shared restoring compare-subtract
    assign bit_in = (state_reg == ST_DIVN) ? num_reg[NUM_W-1] : 1'b0;
    assign rem_sh = {rem_reg[NUM_W-2:0], bit_in};
    assign trial  = {1'b0, rem_sh} - {2'b00, div_reg};
    assign ge     = !trial[NUM_W];
    assign q_sh   = {q_reg[QW-2:0], ge};

    assign i_eff   = (idx_reg >= n_reg) ? '0 : idx_reg;
    assign is_last = (i_eff == n_reg - IDX_W'(1));

    assign a32  = {ph_reg, {(32 - PHASE_BITS){1'b0}}};
    assign z_in = $signed({a32[31], a32});

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = $signed({1'b0, atan_turn(5'(cnt_reg))});

    assign y_c   = (y_reg > Y_MAX) ? SMP_W'(Y_MAX) :
                   (y_reg < Y_MIN) ? SMP_W'(Y_MIN) : SMP_W'(y_reg);
    assign y_off = 17'({y_c[SMP_W-1], y_c}) + 17'd32768;
    assign prod  = 32'(y_off) * 32'd65535;

    always_comb begin
        state_next = state_reg;
        sr_next    = sr_reg;
        tf_next    = tf_reg;
        wf_next    = wf_reg;
        idx_next   = idx_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        ml_next    = ml_reg;
        num_next   = num_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        ph_next    = ph_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        s_tready   = (state_reg == ST_IDLE);

        if (wr_en) begin
            case (paddr[3:2])
                REG_SAMPLE_RATE: sr_next = pwdata[SR_W-1:0];
                REG_TONE_FREQ:   tf_next = pwdata[TF_W-1:0];
                REG_WAVEFORM:    wf_next = pwdata[0];
                default: ;
            endcase
        end

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[0]) begin
                        idx_next = '0;
                    end
                    num_next   = NUM_W'(sr_reg) + NUM_W'(f_eff) - NUM_W'(1);
                    div_next   = IDX_W'(f_eff);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN: begin
                rem_next = ge ? trial[NUM_W-1:0] : rem_sh;
                q_next   = q_sh;
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    n_next     = (q_sh[NUM_W-1:0] == '0) ? IDX_W'(1) : q_sh[IDX_W-1:0];
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                last_next = is_last;
                idx_next  = is_last ? '0 : i_eff + IDX_W'(1);
                if (wf_reg) begin
                    val_next   = (i_eff < (n_reg >> 1)) ? SQ_HIGH : SQ_LOW;
                    state_next = ST_DONE;
                end else begin
                    rem_next   = NUM_W'(i_eff);
                    div_next   = n_reg;
                    cnt_next   = '0;
                    state_next = ST_DIVP;
                end
            end
            ST_DIVP: begin
                rem_next = ge ? trial[NUM_W-1:0] : rem_sh;
                q_next   = q_sh;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PHASE_BITS - 1)) begin
                    ph_next    = q_sh[PHASE_BITS-1:0];
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT: begin
                // fold the angle into [-quarter, quarter] turn
                if (z_in > QUARTER) begin
                    z_next = HALF - z_in;
                end else if (z_in < -QUARTER) begin
                    z_next = -HALF - z_in;
                end else begin
                    z_next = z_in;
                end
                x_next     = CORDIC_GAIN;
                y_next     = '0;
                cnt_next   = '0;
                state_next = ST_CORD;
            end
            ST_CORD: begin
                if (!z_reg[32]) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                val_next   = $signed({1'b0, prod[31:17]});
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = val_reg;
                    ml_next    = last_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sr_reg    <= SAMPLE_RATE_RST;
            tf_reg    <= TONE_FREQ_RST;
            wf_reg    <= 1'b0;
            idx_reg   <= '0;
            mv_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sr_reg    <= sr_next;
            tf_reg    <= tf_next;
            wf_reg    <= wf_next;
            idx_reg   <= idx_next;
            mv_reg    <= mv_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        md_reg   <= md_next;
        ml_reg   <= ml_next;
        num_reg  <= num_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        n_reg    <= n_next;
        ph_reg   <= ph_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

    always_comb begin
        case (paddr[3:2])
            REG_SAMPLE_RATE: prdata = 32'(sr_reg);
            REG_TONE_FREQ:   prdata = 32'(tf_reg);
            REG_WAVEFORM:    prdata = 32'(wf_reg);
            default:         prdata = '0;
        endcase
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a beat is in progress");

    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP) |-> (n_reg != '0))
        else $error("period length is zero");

    a_index_in_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVP) |-> (idx_reg < n_reg))
        else $error("next index outside the period");

    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != 16'h8000))
        else $error("sample outside -32767..32767");

endmodule
